// ===== rtl/gda_pkg.sv =====
// Shared types, constants and calendar tables for the Gregorian date attribute pipeline.
// No dependencies.
package gda_pkg;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_MONTH = 2'd1,
		ST_BAD_DAY   = 2'd2
	} gda_status_t;

	// Year bias: a multiple of 400 years (so leap rule and weekday repeat) minus one.
	// Biased value a = year + 32800 - 1 is always non-negative and fits 17 bits.
	localparam logic [16:0] YEAR_BIAS = 17'd32799;

	// floor(a / 100) = (a * RECIP_100) >> RECIP_100_SHIFT, exact for a < 91180.
	localparam logic [16:0] RECIP_100       = 17'd83887;
	localparam int unsigned RECIP_100_SHIFT = 23;

	// floor(x / 7) = (x * RECIP_7) >> 12, exact for x < 682.
	localparam logic [9:0]  RECIP_7 = 10'd586;

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	typedef struct packed {
		gda_status_t status;
		logic        leap;
		logic [8:0]  doy;
		logic [2:0]  jan1_wd;
	} gda_cal_t;

	// Remainder modulo 7 by folding octal digits, since 8 is 1 modulo 7.
	function automatic logic [2:0] mod7(input logic [16:0] v);
		logic [5:0] s;
		logic [3:0] t;
		logic [2:0] w;
		s = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12])
		    + 6'(v[16:15]);
		t = 4'(s[5:3]) + 4'(s[2:0]);
		w = 3'(4'(t[3]) + 4'(t[2:0]));
		return (w == 3'd7) ? 3'd0 : w;
	endfunction

	// Days before the first of the month in a common year.
	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] r;
		case (m)
			MONTH_FEB:               r = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
			default:                 r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/gda_calendar.sv =====
// Stages 1 to 4: date check, leap flag, day of year and weekday of January 1st.
// Depends on gda_pkg.
module gda_calendar import gda_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day,
	output logic        cal_valid,
	input  logic        cal_stall,
	output gda_cal_t    cal
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic ld1, ld2, ld3, ld4;

	logic [16:0] a_s1;
	logic [3:0]  month_s1, month_s2, month_s3;
	logic [4:0]  day_s1, day_s2, day_s3;

	logic [33:0] prod_s2;
	logic [16:0] a_s2;
	logic [2:0]  m7a_s2, m7a4_s2;

	logic [9:0]  q_s3;
	logic [6:0]  r_s3;
	logic [1:0]  alow_s3;
	logic [2:0]  m7a_s3, m7a4_s3;

	gda_cal_t    cal_s4;

	logic [9:0]  q_next;
	logic [16:0] rem_full;
	gda_cal_t    cal_next;

	// A stage loads when it is empty or its contents move on.
	assign ld4      = !v_s4 || !cal_stall;
	assign ld3      = !v_s3 || ld4;
	assign ld2      = !v_s2 || ld3;
	assign ld1      = !v_s1 || ld2;
	assign in_stall = !ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ld1) v_s1 <= in_valid;
			if (ld2) v_s2 <= v_s1;
			if (ld3) v_s3 <= v_s2;
			if (ld4) v_s4 <= v_s3;
		end
	end

	assign q_next   = prod_s2[32:RECIP_100_SHIFT];
	assign rem_full = a_s2 - 17'({7'b0, q_next} * 17'd100);

	always_ff @(posedge clk) begin
		if (ld1) begin
			a_s1     <= {year[15], year} + YEAR_BIAS;
			month_s1 <= month;
			day_s1   <= day;
		end
		if (ld2) begin
			prod_s2  <= {17'b0, a_s1} * {17'b0, RECIP_100};
			a_s2     <= a_s1;
			m7a_s2   <= mod7(a_s1);
			m7a4_s2  <= mod7({2'b0, a_s1[16:2]});
			month_s2 <= month_s1;
			day_s2   <= day_s1;
		end
		if (ld3) begin
			q_s3     <= q_next;
			r_s3     <= rem_full[6:0];
			alow_s3  <= a_s2[1:0];
			m7a_s3   <= m7a_s2;
			m7a4_s3  <= m7a4_s2;
			month_s3 <= month_s2;
			day_s3   <= day_s2;
		end
		if (ld4) begin
			cal_s4 <= cal_next;
		end
	end

	// With u = a + 1 the year modulo 400: u divisible by 4 when a ends in 3,
	// u divisible by 100 when a mod 100 is 99, by 400 when also q mod 4 is 3.
	always_comb begin
		logic       leap;
		logic [2:0] mq, mq4;
		logic [5:0] wsum;
		logic [4:0] mlen;
		leap = ((alow_s3 == 2'd3) && (r_s3 != 7'd99))
		       || ((q_s3[1:0] == 2'd3) && (r_s3 == 7'd99));
		mq   = mod7({7'b0, q_s3});
		mq4  = mod7({9'b0, q_s3[9:2]});
		// Weekday of January 1st; the constant offsets sum to a multiple of 7.
		wsum = 6'(m7a_s3) + 6'(m7a4_s3) + (6'd7 - 6'(mq)) + 6'(mq4);
		mlen = month_len(month_s3, leap);
		cal_next.jan1_wd = mod7({11'b0, wsum});
		cal_next.leap    = 1'b0;
		cal_next.doy     = 9'd0;
		if (!(month_s3 inside {[MONTH_JAN:MONTH_DEC]})) begin
			cal_next.status = ST_BAD_MONTH;
		end else if (day_s3 == 5'd0 || day_s3 > mlen) begin
			cal_next.status = ST_BAD_DAY;
		end else begin
			cal_next.status = ST_OK;
			cal_next.leap   = leap;
			cal_next.doy    = days_before(month_s3)
			                  + 9'(leap && (month_s3 > MONTH_FEB)) + 9'(day_s3);
		end
	end

	assign cal_valid = v_s4;
	assign cal       = cal_s4;

	a_doy_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && cal_s4.status == ST_OK |-> cal_s4.doy >= 9'd1 && cal_s4.doy <= 9'd366)
		else $error("day of year out of range on a valid date");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && cal_s4.status != ST_OK |-> !cal_s4.leap && cal_s4.doy == 9'd0)
		else $error("rejected date carries nonzero fields");

	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && cal_stall |=> v_s4 && $stable(cal_s4))
		else $error("stage 4 changed while held");

endmodule

// ===== rtl/gda_week.sv =====
// Stages 5 and 6: weekday of the date and Monday-based week number, output register.
// Depends on gda_pkg.
module gda_week import gda_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cal_valid,
	output logic       cal_stall,
	input  gda_cal_t   cal,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic       leap_year,
	output logic [8:0] day_of_year,
	output logic [2:0] weekday,
	output logic [5:0] week_number
);

	logic v_s5, v_s6;
	logic ld5, ld6;

	logic [8:0]  x_s5;
	logic [18:0] prod_s5;
	gda_status_t status_s5;
	logic        leap_s5;
	logic [8:0]  doy_s5;

	gda_status_t status_s6;
	logic        leap_s6;
	logic [8:0]  doy_s6;
	logic [2:0]  wd_s6;
	logic [5:0]  wk_s6;

	logic [3:0]  jan1_adj;
	logic [8:0]  x_next;
	logic [5:0]  wk_next;
	logic [8:0]  wd_full;

	assign ld6       = !v_s6 || !out_stall;
	assign ld5       = !v_s5 || ld6;
	assign cal_stall = !ld5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (ld5) v_s5 <= cal_valid;
			if (ld6) v_s6 <= v_s5;
		end
	end

	// Days before the first Monday fall in week 0: count from the last Monday before Jan 1.
	assign jan1_adj = (cal.jan1_wd == 3'd0) ? 4'd7 : {1'b0, cal.jan1_wd};
	assign x_next   = cal.doy - 9'd1 + 9'(jan1_adj);

	// x mod 7 equals the weekday of the date, since x is congruent to doy - 1 + Jan 1 weekday.
	assign wk_next = prod_s5[17:12];
	assign wd_full = x_s5 - ({wk_next, 3'b0} - {3'b0, wk_next});

	always_ff @(posedge clk) begin
		if (ld5) begin
			x_s5      <= x_next;
			prod_s5   <= {10'b0, x_next} * {9'b0, RECIP_7};
			status_s5 <= cal.status;
			leap_s5   <= cal.leap;
			doy_s5    <= cal.doy;
		end
		if (ld6) begin
			status_s6 <= status_s5;
			leap_s6   <= leap_s5;
			doy_s6    <= doy_s5;
			if (status_s5 == ST_OK) begin
				wd_s6 <= wd_full[2:0];
				wk_s6 <= wk_next;
			end else begin
				wd_s6 <= 3'd0;
				wk_s6 <= 6'd0;
			end
		end
	end

	assign out_valid   = v_s6;
	assign status      = status_s6;
	assign leap_year   = leap_s6;
	assign day_of_year = doy_s6;
	assign weekday     = wd_s6;
	assign week_number = wk_s6;

	a_wd_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> wd_s6 <= 3'd6 && wk_s6 <= 6'd53)
		else $error("weekday or week number out of range");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && status_s6 != ST_OK |-> wd_s6 == 3'd0 && wk_s6 == 6'd0 && doy_s6 == 9'd0)
		else $error("rejected date carries nonzero fields");

	a_week_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && status_s6 == ST_OK |-> {wk_s6, 3'b0} - {3'b0, wk_s6} <= doy_s6 + 9'd6)
		else $error("week number too large for the day of year");

endmodule

// ===== rtl/gregorian_date_attributes_top.sv =====
// Gregorian date attribute block: leap flag, day of year, weekday and week number.
// Instantiates gda_calendar and gda_week; depends on gda_pkg.
//
// Input channel: in_valid, in_stall, with year (signed, year 0 exists), month, day.
// Output channel: out_valid, out_stall, with status, leap_year, day_of_year,
// weekday (0 is Monday) and week_number (days before the first Monday are week 0).
// Each accepted item yields exactly one result item, in order.
// An item is accepted at a rising edge with valid high and stall low.
// An accepted item moves from stage 1 through stage 6, which drives the output.
// One item per cycle is sustained while out_stall is low; the six pipeline
// stages each load when empty or when the stage after them moves.
// When out_stall is held, the output holds its item and the stages behind it
// keep filling; in_stall rises only once all six stages are occupied, and
// a bubble anywhere in the pipeline is closed up while the output waits.
// Reset (arst_n low) empties the pipeline at once; no item is lost or
// repeated across a stall. Invalid month or day gives zeros in all numeric
// fields, and the leap flag is zero too.
module gregorian_date_attributes_top import gda_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        leap_year,
	output logic [8:0]  day_of_year,
	output logic [2:0]  weekday,
	output logic [5:0]  week_number
);

	logic     cal_valid;
	logic     cal_stall;
	gda_cal_t cal;

	gda_calendar u_calendar (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.year      (year),
		.month     (month),
		.day       (day),
		.cal_valid (cal_valid),
		.cal_stall (cal_stall),
		.cal       (cal)
	);

	gda_week u_week (
		.clk         (clk),
		.arst_n      (arst_n),
		.cal_valid   (cal_valid),
		.cal_stall   (cal_stall),
		.cal         (cal),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.leap_year   (leap_year),
		.day_of_year (day_of_year),
		.weekday     (weekday),
		.week_number (week_number)
	);

endmodule

// ===== dv/gregorian_date_attributes_top_tb.sv =====
// Self-checking testbench for gregorian_date_attributes_top: directed and random dates
// checked against typed results or a predictor, under random idling and stalls on both sides.
// Depends on gda_pkg and the RTL under rtl/.
module gregorian_date_attributes_top_tb import gda_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ANCHOR_YEAR = 2024;  // Jan 1 of this year is a Monday
	localparam int MONTH_DAYS [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	localparam int CYCLE_LIMIT = 200_000;
	localparam int HOLD_CYCLES = 200;
	localparam int DRAIN_CYCLES = 12;
	localparam int RANDOM_PER_PHASE = 375;

	typedef struct packed {
		gda_status_t status;
		logic        leap;
		logic [8:0]  doy;
		logic [2:0]  wd;
		logic [5:0]  week;
	} date_attr_t;

	typedef struct {
		logic [15:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		bit          typed;
		date_attr_t  result;
	} date_case_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] year = '0;
	logic [3:0]  month = '0;
	logic [4:0]  day = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic        leap_year;
	logic [8:0]  day_of_year;
	logic [2:0]  weekday;
	logic [5:0]  week_number;

	date_attr_t pending_attrs[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_request = 1'b0;
	int dates_sent = 0;
	int invalid_dates = 0;
	int results_checked = 0;
	int error_count = 0;
	int backpressure_cycles = 0;
	int cycle_count = 0;

	// Rows with typed = 1 carry their result; the rest are checked against the predictor.
	date_case_t directed_cases[] = '{
		'{16'd2024, 4'd1, 5'd1, 1'b1, '{ST_OK, 1'b1, 9'd1, 3'd0, 6'd1}},
		'{16'd2024, 4'd0, 5'd1, 1'b1, '{ST_BAD_MONTH, 1'b0, 9'd0, 3'd0, 6'd0}},
		'{16'd2024, 4'd13, 5'd1, 1'b1, '{ST_BAD_MONTH, 1'b0, 9'd0, 3'd0, 6'd0}},
		'{16'd2024, 4'd15, 5'd31, 1'b1, '{ST_BAD_MONTH, 1'b0, 9'd0, 3'd0, 6'd0}},
		'{16'd2023, 4'd0, 5'd0, 1'b1, '{ST_BAD_MONTH, 1'b0, 9'd0, 3'd0, 6'd0}},
		'{16'd2024, 4'd1, 5'd0, 1'b1, '{ST_BAD_DAY, 1'b0, 9'd0, 3'd0, 6'd0}},
		'{16'd2023, 4'd2, 5'd29, 1'b1, '{ST_BAD_DAY, 1'b0, 9'd0, 3'd0, 6'd0}},
		'{16'd1900, 4'd2, 5'd29, 1'b1, '{ST_BAD_DAY, 1'b0, 9'd0, 3'd0, 6'd0}},
		'{16'(-100), 4'd2, 5'd29, 1'b1, '{ST_BAD_DAY, 1'b0, 9'd0, 3'd0, 6'd0}},
		'{16'd2024, 4'd4, 5'd31, 1'b1, '{ST_BAD_DAY, 1'b0, 9'd0, 3'd0, 6'd0}},
		'{16'd2024, 4'd6, 5'd31, 1'b1, '{ST_BAD_DAY, 1'b0, 9'd0, 3'd0, 6'd0}},
		'{16'd2024, 4'd12, 5'd31, 1'b0, '0},
		'{16'd2024, 4'd2, 5'd29, 1'b0, '0},
		'{16'd2000, 4'd2, 5'd29, 1'b0, '0},
		'{16'd0, 4'd2, 5'd29, 1'b0, '0},
		'{16'd0, 4'd1, 5'd1, 1'b0, '0},
		'{16'(-1), 4'd12, 5'd31, 1'b0, '0},
		'{16'(-400), 4'd2, 5'd29, 1'b0, '0},
		'{16'h8000, 4'd1, 5'd1, 1'b0, '0},
		'{16'h8000, 4'd12, 5'd31, 1'b0, '0},
		'{16'h7fff, 4'd1, 5'd1, 1'b0, '0},
		'{16'h7fff, 4'd12, 5'd31, 1'b0, '0},
		'{16'd2023, 4'd1, 5'd1, 1'b0, '0},
		'{16'd2024, 4'd12, 5'd30, 1'b0, '0},
		'{16'd2024, 4'd9, 5'd30, 1'b0, '0}
	};

	gregorian_date_attributes_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.year        (year),
		.month       (month),
		.day         (day),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.leap_year   (leap_year),
		.day_of_year (day_of_year),
		.weekday     (weekday),
		.week_number (week_number)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int floor_quot(input int a, input int b);
		int q;
		q = a / b;
		if ((a % b != 0) && ((a < 0) != (b < 0)))
			q--;
		return q;
	endfunction

	function automatic int floor_rem(input int a, input int b);
		return a - b * floor_quot(a, b);
	endfunction

	function automatic bit is_leap(input int y);
		return (floor_rem(y, 4) == 0 && floor_rem(y, 100) != 0) || floor_rem(y, 400) == 0;
	endfunction

	function automatic int month_length(input int y, input int m);
		return MONTH_DAYS[m] + ((m == MONTH_FEB && is_leap(y)) ? 1 : 0);
	endfunction

	// Days from Jan 1 of year 0 to Jan 1 of year y, with floor division for negative years.
	function automatic int days_to_jan1(input int y);
		return 365 * y + floor_quot(y + 3, 4) - floor_quot(y + 99, 100) + floor_quot(y + 399, 400);
	endfunction

	function automatic int monday_index(input int y, input int doy);
		return floor_rem(days_to_jan1(y) - days_to_jan1(ANCHOR_YEAR) + doy - 1, 7);
	endfunction

	function automatic date_attr_t predict_attrs(input logic [15:0] y_bits, input logic [3:0] m,
			input logic [4:0] d);
		date_attr_t r;
		int y;
		int doy;
		int jan1;
		r = '0;
		y = int'($signed(y_bits));
		if (m < MONTH_JAN || m > MONTH_DEC) begin
			r.status = ST_BAD_MONTH;
			return r;
		end
		if (d < 1 || d > month_length(y, m)) begin
			r.status = ST_BAD_DAY;
			return r;
		end
		doy = d;
		for (int i = 1; i < m; i++)
			doy += month_length(y, i);
		jan1 = monday_index(y, 1);
		r.leap = is_leap(y);
		r.doy = 9'(doy);
		r.wd = 3'(monday_index(y, doy));
		r.week = 6'((doy - 1 + (jan1 == 0 ? 7 : jan1)) / 7);
		return r;
	endfunction

	// Holds the item until accepted, then records what the block must return for it.
	task automatic offer_date(input logic [15:0] y, input logic [3:0] m, input logic [4:0] d,
			input date_attr_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		year <= y;
		month <= m;
		day <= d;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_attrs.push_back(want);
		dates_sent++;
		if (want.status != ST_OK)
			invalid_dates++;
	endtask

	function automatic logic [15:0] pick_year();
		case ($urandom_range(3))
			0: return 16'($urandom_range(65535));
			1: return 16'(ANCHOR_YEAR + $urandom_range(1000) - 500);
			2: return 16'($urandom_range(1000) - 500);
			default: return 16'(100 * ($urandom_range(654) - 327));
		endcase
	endfunction

	// Mostly well-formed dates, with some fully random month and day values mixed in.
	task automatic send_random_dates(input int count);
		logic [15:0] y;
		logic [3:0] m;
		logic [4:0] d;
		for (int n = 0; n < count; n++) begin
			y = pick_year();
			if ($urandom_range(9) == 0) begin
				m = 4'($urandom_range(15));
				d = 5'($urandom_range(31));
			end else begin
				m = 4'($urandom_range(12, 1));
				d = 5'($urandom_range(month_length(int'($signed(y)), m), 1));
			end
			offer_date(y, m, d, predict_attrs(y, m, d));
		end
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1)
					@(posedge clk);
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		date_attr_t got;
		date_attr_t want;
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
				pending_attrs.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
		if (in_valid && in_stall)
			backpressure_cycles++;
		if (arst_n && out_valid && !out_stall) begin
			got.status = gda_status_t'(status);
			got.leap = leap_year;
			got.doy = day_of_year;
			got.wd = weekday;
			got.week = week_number;
			if (pending_attrs.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("Unexpected result: status %0d doy %0d", got.status, got.doy);
			end else begin
				want = pending_attrs.pop_front();
				if (got !== want) begin
					error_count++;
					if (error_count <= 10) begin
						$display("Mismatch on result %0d: expected status %0d leap %0d doy %0d weekday %0d week %0d",
							results_checked, want.status, want.leap, want.doy, want.wd,
							want.week);
						$display("  got status %0d leap %0d doy %0d weekday %0d week %0d",
							got.status, got.leap, got.doy, got.wd, got.week);
					end
				end
			end
			results_checked++;
		end
	end

	initial begin
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_cases[i])
			offer_date(directed_cases[i].year, directed_cases[i].month, directed_cases[i].day,
				directed_cases[i].typed ? directed_cases[i].result :
				predict_attrs(directed_cases[i].year, directed_cases[i].month,
					directed_cases[i].day));

		// Full rate, starting with a long output hold so that the pipeline fills up.
		hold_request = 1'b1;
		send_random_dates(RANDOM_PER_PHASE);
		send_idle_pct = 63;
		send_random_dates(RANDOM_PER_PHASE);
		send_idle_pct = 0;
		recv_stall_pct = 63;
		send_random_dates(RANDOM_PER_PHASE);
		send_idle_pct = 25;
		recv_stall_pct = 25;
		send_random_dates(RANDOM_PER_PHASE);
		in_valid <= 1'b0;

		while (pending_attrs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("Sent %0d dates, %0d of them with a bad month or day; %0d results checked.",
			dates_sent, invalid_dates, results_checked);
		$display("Input was held off for %0d cycles while items were offered.",
			backpressure_cycles);
		if (error_count == 0 && results_checked == dates_sent)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
